// ===== rtl/core/manchester_frame_decoder_macros.svh =====
// Assertion helpers shared by the decoder RTL.
// Every property is sampled on aclk and held off while aresetn is low.
`ifndef MANCHESTER_FRAME_DECODER_MACROS_SVH
`define MANCHESTER_FRAME_DECODER_MACROS_SVH

// Same-cycle implication.
`define MFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mfd assertion failed");

// Next-cycle implication.
`define MFD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mfd assertion failed");

`endif

// ===== rtl/core/mfd_pkg.sv =====
package mfd_pkg;

    // Field and register widths
    localparam int DurationBits   = 24;
    localparam int CfgWidth       = 16;
    localparam int CfgAddrBits    = 2;
    localparam int QueueDepth     = 4;
    localparam int QueuePtrBits   = $clog2(QueueDepth);
    localparam int QueueLevelBits = $clog2(QueueDepth + 1);

    localparam logic [15:0] CrcSeed   = 16'h6363;
    localparam logic [3:0]  FullCount = 4'd8;

    // Configuration register indexes
    localparam logic [CfgAddrBits-1:0] REG_FULL_PERIOD = 2'd0;
    localparam logic [CfgAddrBits-1:0] REG_HALF_PERIOD = 2'd1;
    localparam logic [CfgAddrBits-1:0] REG_TOLERANCE   = 2'd2;

    localparam logic [CfgWidth-1:0] FullPeriodReset = 16'd9440;
    localparam logic [CfgWidth-1:0] HalfPeriodReset = 16'd4720;
    localparam logic [CfgWidth-1:0] ToleranceReset  = 16'd1180;

    // Result kinds
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_BYTE    = 2'd1;
    localparam logic [1:0] KIND_PARTIAL = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE_SHORT,
        ST_IDLE_GAP,
        ST_HALF,
        ST_FULL
    } framer_state_t;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_BIT,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      data_bit;
    } cmd_t;

    typedef struct packed {
        logic                      empty;
        logic                      full;
        logic [QueueLevelBits-1:0] level;
    } q_status_t;

    typedef struct packed {
        logic [DurationBits-1:0] duration;
        logic                    new_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] data_byte;
        logic       parity_bit;
        logic       parity_ok;
        logic [3:0] bit_len;
        logic       crc_ok;
        logic       bcc_ok;
        logic       last;
    } out_item_t;

    // CRC_A update over one byte
    function automatic logic [15:0] crc_a_update(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [7:0] b;
        b = data ^ crc[7:0];
        b = b ^ {b[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {b, 8'h00} ^ {5'b00000, b, 3'b000}
             ^ {12'h000, b[7:4]};
    endfunction

endpackage

// ===== rtl/core/mfd_front.sv =====
module mfd_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mfd_pkg::CfgAddrBits-1:0]     cfg_addr,
    input  logic [mfd_pkg::CfgWidth-1:0]        cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mfd_pkg::in_item_t                   s_data,
    input  mfd_pkg::q_status_t                  q_status,
    output logic                                push,
    output mfd_pkg::cmd_t                       push_cmd
);

    localparam int CmpBits = mfd_pkg::DurationBits + 1;

    logic [mfd_pkg::CfgWidth-1:0] full_period_reg;
    logic [mfd_pkg::CfgWidth-1:0] half_period_reg;
    logic [mfd_pkg::CfgWidth-1:0] tolerance_reg;

    mfd_pkg::framer_state_t state_reg, state_next;

    logic [CmpBits-1:0] dur_ext, tol_ext, half_ext, full_ext;
    logic               is_half, is_full, is_gap;
    logic               accept;
    logic               cmd_valid;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_period_reg <= mfd_pkg::FullPeriodReset;
            half_period_reg <= mfd_pkg::HalfPeriodReset;
            tolerance_reg   <= mfd_pkg::ToleranceReset;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mfd_pkg::REG_FULL_PERIOD: full_period_reg <= cfg_wdata;
                mfd_pkg::REG_HALF_PERIOD: half_period_reg <= cfg_wdata;
                mfd_pkg::REG_TOLERANCE:   tolerance_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Classify the duration against the windows; x > n - t is tested as x + t > n
    assign dur_ext  = CmpBits'(s_data.duration);
    assign tol_ext  = CmpBits'(tolerance_reg);
    assign half_ext = CmpBits'(half_period_reg);
    assign full_ext = CmpBits'(full_period_reg);

    assign is_half = (dur_ext + tol_ext > half_ext) && (dur_ext < half_ext + tol_ext);
    assign is_full = (dur_ext + tol_ext > full_ext) && (dur_ext < full_ext + tol_ext);
    assign is_gap  = dur_ext > full_ext + tol_ext;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mfd_pkg::ST_IDLE_SHORT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Framer: next state and the command for the back end
    always_comb begin
        state_next        = state_reg;
        cmd_valid         = 1'b0;
        push_cmd.kind     = mfd_pkg::CMD_BIT;
        push_cmd.data_bit = ~s_data.new_level;
        if (accept) begin
            unique case (state_reg)
                mfd_pkg::ST_IDLE_SHORT: begin
                    if (is_gap) state_next = mfd_pkg::ST_IDLE_GAP;
                end
                mfd_pkg::ST_IDLE_GAP: begin
                    if (is_half) begin
                        cmd_valid     = 1'b1;
                        push_cmd.kind = mfd_pkg::CMD_START;
                        state_next    = mfd_pkg::ST_HALF;
                    end else if (!is_gap) begin
                        state_next = mfd_pkg::ST_IDLE_SHORT;
                    end
                end
                mfd_pkg::ST_HALF: begin
                    if (is_half) begin
                        state_next = mfd_pkg::ST_FULL;
                    end else if (is_full) begin
                        cmd_valid = 1'b1;
                    end else if (is_gap) begin
                        cmd_valid     = 1'b1;
                        push_cmd.kind = mfd_pkg::CMD_END;
                        state_next    = mfd_pkg::ST_IDLE_GAP;
                    end
                end
                mfd_pkg::ST_FULL: begin
                    if (is_half) begin
                        cmd_valid  = 1'b1;
                        state_next = mfd_pkg::ST_HALF;
                    end else if (is_full) begin
                        cmd_valid     = 1'b1;
                        push_cmd.kind = mfd_pkg::CMD_END;
                        state_next    = mfd_pkg::ST_IDLE_SHORT;
                    end else if (is_gap) begin
                        cmd_valid     = 1'b1;
                        push_cmd.kind = mfd_pkg::CMD_END;
                        state_next    = mfd_pkg::ST_IDLE_GAP;
                    end
                end
                default: state_next = mfd_pkg::ST_IDLE_SHORT;
            endcase
        end
    end

    assign push = cmd_valid;

endmodule

// ===== rtl/core/mfd_queue.sv =====
module mfd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  mfd_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output mfd_pkg::cmd_t      head,
    output mfd_pkg::q_status_t status
);

    mfd_pkg::cmd_t entry_reg [mfd_pkg::QueueDepth];

    logic [mfd_pkg::QueuePtrBits-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mfd_pkg::QueuePtrBits-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mfd_pkg::QueueLevelBits-1:0] level_reg, level_next;

    // Store a command at the write pointer
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and level
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.empty = (level_reg == '0);
    assign status.full  = (level_reg == mfd_pkg::QueueLevelBits'(mfd_pkg::QueueDepth));
    assign status.level = level_reg;

endmodule

// ===== rtl/core/mfd_back.sv =====
module mfd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  mfd_pkg::cmd_t      head,
    input  mfd_pkg::q_status_t q_status,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output mfd_pkg::out_item_t m_data
);

    logic [7:0]  shift_reg, shift_next;
    logic [3:0]  count_reg, count_next;
    logic        parity_reg, parity_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  xor_reg, xor_next;
    logic        have_reg, have_next;
    logic        split_reg, split_next;
    logic        out_valid_reg, out_valid_next;
    mfd_pkg::out_item_t out_data_reg, out_data_next;

    logic               out_free;
    logic               emit;
    logic               par_new;
    mfd_pkg::out_item_t res;

    assign out_free = !out_valid_reg || m_ready;
    assign par_new  = parity_reg ^ head.data_bit;

    // Carry out the command at the queue head
    always_comb begin
        shift_next  = shift_reg;
        count_next  = count_reg;
        parity_next = parity_reg;
        crc_next    = crc_reg;
        xor_next    = xor_reg;
        have_next   = have_reg;
        split_next  = split_reg;
        pop         = 1'b0;
        emit        = 1'b0;
        res         = '0;
        if (!q_status.empty && out_free) begin
            unique case (head.kind)
                mfd_pkg::CMD_START: begin
                    pop             = 1'b1;
                    emit            = 1'b1;
                    res.result_kind = mfd_pkg::KIND_START;
                    res.last        = 1'b1;
                end
                mfd_pkg::CMD_BIT: begin
                    pop = 1'b1;
                    if (count_reg == mfd_pkg::FullCount) begin
                        // parity bit closes the byte
                        emit            = 1'b1;
                        res.result_kind = mfd_pkg::KIND_BYTE;
                        res.data_byte   = shift_reg;
                        res.parity_bit  = head.data_bit;
                        res.parity_ok   = par_new;
                        res.bit_len     = mfd_pkg::FullCount;
                        res.last        = 1'b1;
                        have_next       = 1'b1;
                        xor_next        = xor_reg ^ shift_reg;
                        crc_next        = mfd_pkg::crc_a_update(crc_reg, shift_reg);
                        shift_next      = '0;
                        count_next      = '0;
                        parity_next     = 1'b0;
                    end else begin
                        shift_next  = shift_reg | ({7'b0000000, head.data_bit} << count_reg[2:0]);
                        count_next  = count_reg + 1'b1;
                        parity_next = par_new;
                    end
                end
                mfd_pkg::CMD_END: begin
                    if (count_reg != '0 && !split_reg) begin
                        // pending bits go out first; hold the command
                        emit            = 1'b1;
                        res.result_kind = mfd_pkg::KIND_PARTIAL;
                        res.data_byte   = shift_reg;
                        res.bit_len     = count_reg;
                        split_next      = 1'b1;
                    end else begin
                        pop             = 1'b1;
                        emit            = 1'b1;
                        res.result_kind = mfd_pkg::KIND_END;
                        res.crc_ok      = have_reg && (crc_reg == '0);
                        res.bcc_ok      = have_reg && (crc_reg != '0) && (xor_reg == '0);
                        res.last        = 1'b1;
                        shift_next      = '0;
                        count_next      = '0;
                        parity_next     = 1'b0;
                        crc_next        = mfd_pkg::CrcSeed;
                        xor_next        = '0;
                        have_next       = 1'b0;
                        split_next      = 1'b0;
                    end
                end
                default: pop = 1'b1;
            endcase
        end
    end

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg     <= '0;
            count_reg     <= '0;
            parity_reg    <= 1'b0;
            crc_reg       <= mfd_pkg::CrcSeed;
            xor_reg       <= '0;
            have_reg      <= 1'b0;
            split_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            parity_reg    <= parity_next;
            crc_reg       <= crc_next;
            xor_reg       <= xor_next;
            have_reg      <= have_next;
            split_reg     <= split_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== rtl/core/manchester_frame_decoder.sv =====
// Channel | Direction | Handshake         | Payload
// s_      | in        | s_valid / s_ready | mfd_pkg::in_item_t  (duration, new_level)
// m_      | out       | m_valid / m_ready | mfd_pkg::out_item_t (one result per transfer)
// cfg_    | in        | cfg_wr_en         | cfg_addr, cfg_wdata (write only)
//
// One event is taken per cycle while the command queue (4 entries) has room.
// Results leave at one per cycle while m_ready is high; a frame end with pending bits
// gives a partial byte, then a frame end, from the back end.
// A first result is registered in the command queue, then in the output register;
// m_ stalls hold it back further.
// aresetn is synchronous; it restores register defaults and the CRC seed.
// m_ stalls back up through the queue until s_ready drops.
`include "manchester_frame_decoder_macros.svh"

module manchester_frame_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [mfd_pkg::CfgAddrBits-1:0] cfg_addr,
    input  logic [mfd_pkg::CfgWidth-1:0]    cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  mfd_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output mfd_pkg::out_item_t              m_data
);

    mfd_pkg::cmd_t      push_cmd;
    mfd_pkg::cmd_t      head;
    mfd_pkg::q_status_t q_status;
    logic               push;
    logic               pop;

    logic               q_almost_full;
    logic               res_is_end;
    logic               res_is_byte;
    logic               res_is_partial;

    mfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    mfd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    mfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Terms for the checks below
    assign q_almost_full  = (q_status.level == mfd_pkg::QueueLevelBits'(mfd_pkg::QueueDepth - 1));
    assign res_is_end     = m_valid && (m_data.result_kind == mfd_pkg::KIND_END);
    assign res_is_byte    = m_valid && (m_data.result_kind == mfd_pkg::KIND_BYTE);
    assign res_is_partial = m_valid && (m_data.result_kind == mfd_pkg::KIND_PARTIAL);

    // Queue never overfills and fills up as counted
    `MFD_ASSERT_IMP(a_push_has_room, push, !q_status.full)
    `MFD_ASSERT_NXT(a_fill_to_full, push && !pop && q_almost_full, q_status.full)
    // Frame end and full byte close the event; a partial byte never does
    `MFD_ASSERT_IMP(a_end_is_last, res_is_end, m_data.last && (m_data.data_byte == '0))
    `MFD_ASSERT_IMP(a_byte_shape, res_is_byte, m_data.last && (m_data.bit_len == mfd_pkg::FullCount))
    `MFD_ASSERT_IMP(a_partial_not_last, res_is_partial, !m_data.last && (m_data.bit_len != '0))

endmodule

// ===== tb/sv/manchester_frame_decoder_test.sv =====
`timescale 1ns / 1ps

module manchester_frame_decoder_test;
    import mfd_pkg::*;

    localparam int StepCount    = 9;
    localparam int SettleCycles = 16;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CfgAddrBits-1:0] cfg_addr  = '0;
    logic [CfgWidth-1:0]    cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;

    // Timing settings per step; steps 0..2 stall the receiver, 3..5 the sender, 6..8 neither
    logic [15:0] step_full[StepCount] = '{16'd9440, 16'd200, 16'd65535, 16'd1, 16'd1000,
                                          16'd16, 16'd9440, 16'd65535, 16'd3000};
    logic [15:0] step_half[StepCount] = '{16'd4720, 16'd100, 16'd32768, 16'd1, 16'd500,
                                          16'd8, 16'd4720, 16'd65535, 16'd1500};
    logic [15:0] step_tol[StepCount]  = '{16'd1180, 16'd30, 16'd8000, 16'd0, 16'd65535,
                                          16'd4, 16'd1180, 16'd65535, 16'd400};
    int unsigned step_events[StepCount]  = '{170, 150, 100, 30, 50, 150, 150, 30, 70};
    int unsigned step_tx_idle[StepCount] = '{10, 10, 10, 67, 67, 67, 0, 0, 0};
    int unsigned step_rx_idle[StepCount] = '{67, 67, 67, 10, 10, 10, 0, 0, 0};

    // Opening sequence at reset timing: window bounds, one full byte, empty frame,
    // frame end on a full period with two pending bits
    int unsigned dir_ticks[25] = '{0, 16777215, 3540, 10620, 10621, 3541,
                                   8261, 10619, 9440, 8261, 10619, 9440, 8261, 10619, 9440,
                                   4720, 9440, 20000, 5899, 30000, 4720, 9440, 9440, 4720,
                                   9000};
    bit dir_level[25] = '{0, 1, 0, 1, 0, 1,
                          0, 1, 0, 1, 1, 0, 1, 0, 0,
                          0, 0, 1, 0, 0, 1, 0, 1, 0, 0};

    // Timing registers as the decoder should hold them
    logic [15:0] full_cfg = FullPeriodReset;
    logic [15:0] half_cfg = HalfPeriodReset;
    logic [15:0] tol_cfg  = ToleranceReset;

    // Decoder state as the predictor tracks it
    framer_state_t line_state = ST_IDLE_SHORT;
    logic [7:0]    byte_acc   = 8'h00;
    logic [3:0]    bits_held  = 4'd0;
    logic          parity_acc = 1'b0;
    logic [15:0]   crc_acc    = CrcSeed;
    logic [7:0]    bcc_acc    = 8'h00;
    logic          got_bytes  = 1'b0;

    in_item_t    pending_events[$];
    out_item_t   event_results[$];
    out_item_t   decoded_results[$];
    out_item_t   oldest_result;
    int unsigned phase_events;
    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    int          mismatches        = 0;
    logic        s_fire            = 1'b0;

    manchester_frame_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Reflected CRC_A, one bit at a time
    function automatic logic [15:0] crc_a_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic in_window(input longint ticks, input logic [15:0] nominal);
        return (ticks > longint'(nominal) - longint'(tol_cfg))
            && (ticks < longint'(nominal) + longint'(tol_cfg));
    endfunction

    function automatic out_item_t blank_result(input logic [1:0] kind);
        out_item_t r;
        r = '0;
        r.result_kind = kind;
        return r;
    endfunction

    function automatic string show_result(input out_item_t r);
        return $sformatf({"kind=%0d byte=%02h pbit=%0b pok=%0b bits=%0d",
                          " crc_ok=%0b bcc_ok=%0b last=%0b"},
                         r.result_kind, r.data_byte, r.parity_bit, r.parity_ok,
                         r.bit_len, r.crc_ok, r.bcc_ok, r.last);
    endfunction

    // Shift one decoded bit in; the ninth bit closes a byte
    task automatic take_bit(input logic b);
        out_item_t r;
        bits_held  = bits_held + 4'd1;
        parity_acc = parity_acc ^ b;
        if (bits_held <= 4'd8) begin
            byte_acc[bits_held - 4'd1] = b;
        end else begin
            r = blank_result(KIND_BYTE);
            r.data_byte  = byte_acc;
            r.parity_bit = b;
            r.parity_ok  = parity_acc;
            r.bit_len    = FullCount;
            event_results.push_back(r);
            got_bytes  = 1'b1;
            bcc_acc    = bcc_acc ^ byte_acc;
            crc_acc    = crc_a_byte(crc_acc, byte_acc);
            byte_acc   = 8'h00;
            bits_held  = 4'd0;
            parity_acc = 1'b0;
        end
    endtask

    // Flush pending bits, report frame status, restore the frame checks
    task automatic close_frame();
        out_item_t r;
        if (bits_held != 4'd0) begin
            r = blank_result(KIND_PARTIAL);
            r.data_byte = byte_acc;
            r.bit_len   = bits_held;
            event_results.push_back(r);
        end
        r = blank_result(KIND_END);
        r.crc_ok = got_bytes && (crc_acc == 16'h0000);
        r.bcc_ok = got_bytes && (crc_acc != 16'h0000) && (bcc_acc == 8'h00);
        event_results.push_back(r);
        byte_acc   = 8'h00;
        bits_held  = 4'd0;
        parity_acc = 1'b0;
        crc_acc    = CrcSeed;
        bcc_acc    = 8'h00;
        got_bytes  = 1'b0;
    endtask

    // Classify one level change, advance the framer and queue its results
    task automatic decode_event(input in_item_t ev);
        longint    ticks;
        logic      is_half;
        logic      is_full;
        logic      is_gap;
        out_item_t r;
        ticks   = longint'(ev.duration);
        is_half = in_window(ticks, half_cfg);
        is_full = in_window(ticks, full_cfg);
        is_gap  = ticks > longint'(full_cfg) + longint'(tol_cfg);
        event_results.delete();
        case (line_state)
            ST_IDLE_SHORT: begin
                if (is_gap) line_state = ST_IDLE_GAP;
            end
            ST_IDLE_GAP: begin
                if (is_half) begin
                    event_results.push_back(blank_result(KIND_START));
                    line_state = ST_HALF;
                end else if (!is_gap) begin
                    line_state = ST_IDLE_SHORT;
                end
            end
            ST_HALF: begin
                if (is_half) begin
                    line_state = ST_FULL;
                end else if (is_full) begin
                    take_bit(~ev.new_level);
                end else if (is_gap) begin
                    close_frame();
                    line_state = ST_IDLE_GAP;
                end
            end
            default: begin
                if (is_half) begin
                    take_bit(~ev.new_level);
                    line_state = ST_HALF;
                end else if (is_full) begin
                    close_frame();
                    line_state = ST_IDLE_SHORT;
                end else if (is_gap) begin
                    close_frame();
                    line_state = ST_IDLE_GAP;
                end
            end
        endcase
        // Flag the final result of this event
        while (event_results.size() != 0) begin
            r = event_results.pop_front();
            r.last = (event_results.size() == 0);
            decoded_results.push_back(r);
        end
    endtask

    function automatic logic coin();
        return 1'($urandom_range(1));
    endfunction

    // Pick a duration strictly inside the window around nominal, ends favored; nominal if the window is empty
    function automatic int unsigned ticks_near(input logic [15:0] nominal);
        int lo;
        int hi;
        lo = int'(nominal) - int'(tol_cfg) + 1;
        hi = int'(nominal) + int'(tol_cfg) - 1;
        if (lo < 0) lo = 0;
        if (lo > hi) return nominal;
        case ($urandom_range(3))
            0:       return unsigned'(lo);
            1:       return unsigned'(hi);
            default: return $urandom_range(unsigned'(hi), unsigned'(lo));
        endcase
    endfunction

    function automatic int unsigned gap_ticks();
        int unsigned floor_gap;
        floor_gap = full_cfg + tol_cfg + 1;
        case ($urandom_range(7))
            0:       return 24'hFF_FFFF;
            1:       return $urandom_range(24'hFF_FFFF, floor_gap);
            default: return floor_gap + $urandom_range(2 * full_cfg);
        endcase
    endfunction

    task automatic queue_event(input int unsigned ticks, input logic level);
        in_item_t ev;
        ev.duration  = ticks[DurationBits-1:0];
        ev.new_level = level;
        pending_events.push_back(ev);
        phase_events++;
    endtask

    // Encode one bit as a full period or as two half periods
    task automatic send_bit(input logic b);
        if (coin()) begin
            queue_event(ticks_near(full_cfg), ~b);
        end else begin
            queue_event(ticks_near(half_cfg), coin());
            queue_event(ticks_near(half_cfg), ~b);
        end
    endtask

    task automatic send_noise(input int unsigned count);
        int unsigned ticks;
        repeat (count) begin
            case ($urandom_range(3))
                0:       ticks = $urandom_range(24'hFF_FFFF);
                1:       ticks = ticks_near(half_cfg);
                2:       ticks = ticks_near(full_cfg);
                default: ticks = $urandom_range(2 * (full_cfg + tol_cfg) + 2);
            endcase
            queue_event(ticks, coin());
        end
    endtask

    // Build one frame: random bytes with CRC, BCC or no trailer, optional
    // trailing bits; a broken frame carries loose bits and noise instead
    task automatic send_frame(input bit tail8, input bit broken);
        logic [7:0]  payload[$];
        logic [15:0] crc;
        logic [7:0]  bcc;
        logic        parity;
        int unsigned tail;
        int unsigned trailer;
        crc = CrcSeed;
        bcc = 8'h00;
        if (!broken) begin
            repeat ($urandom_range(4)) payload.push_back(8'($urandom_range(255)));
        end
        foreach (payload[i]) begin
            crc = crc_a_byte(crc, payload[i]);
            bcc = bcc ^ payload[i];
        end
        trailer = $urandom_range(9);
        if (!broken && trailer < 5) begin
            payload.push_back(crc[7:0]);
            payload.push_back(crc[15:8]);
        end else if (!broken && trailer < 7) begin
            payload.push_back(bcc);
        end
        // Gap, then the half period that opens the frame
        queue_event(gap_ticks(), coin());
        queue_event(ticks_near(half_cfg), coin());
        foreach (payload[i]) begin
            if ($urandom_range(19) == 0) send_noise(1);
            for (int k = 0; k < 8; k++) begin
                send_bit(payload[i][k]);
            end
            parity = ~^payload[i];
            if ($urandom_range(9) == 0) parity = ~parity;
            send_bit(parity);
        end
        if (broken) tail = $urandom_range(14, 1);
        else if (tail8) tail = 8;
        else tail = ($urandom_range(9) < 3) ? $urandom_range(8, 1) : 0;
        repeat (tail) send_bit(coin());
        if (broken) send_noise($urandom_range(3, 1));
        // Close on a gap, or on a full period after a half
        case ($urandom_range(2))
            0: queue_event(gap_ticks(), coin());
            1: begin
                queue_event(ticks_near(half_cfg), coin());
                queue_event(ticks_near(full_cfg), coin());
            end
            default: begin
                queue_event(ticks_near(half_cfg), coin());
                queue_event(gap_ticks(), coin());
            end
        endcase
    endtask

    // Write all three timing registers on back-to-back cycles
    task automatic load_timing(input logic [15:0] full_v, input logic [15:0] half_v,
                               input logic [15:0] tol_v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_FULL_PERIOD;
        cfg_wdata <= full_v;
        @(negedge aclk);
        cfg_addr  <= REG_HALF_PERIOD;
        cfg_wdata <= half_v;
        @(negedge aclk);
        cfg_addr  <= REG_TOLERANCE;
        cfg_wdata <= tol_v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        full_cfg = full_v;
        half_cfg = half_v;
        tol_cfg  = tol_v;
    endtask

    // Hold until every event is taken and every result is back, then settle;
    // look again after settling since the last event may have just gone out
    task automatic wait_drained();
        forever begin
            while (pending_events.size() != 0 || s_valid || decoded_results.size() != 0) begin
                @(negedge aclk);
            end
            repeat (SettleCycles) @(negedge aclk);
            if (pending_events.size() == 0 && !s_valid && decoded_results.size() == 0) break;
        end
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("manchester_frame_decoder verification failed");
        $finish;
    end

    // Drive events and receiver stalls on the falling edge
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= receiver_idle_pct);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_data  <= pending_events.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Predict on each event transfer, check each result transfer
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) decode_event(s_data);
            if (m_valid && m_ready) begin
                if (decoded_results.size() == 0) begin
                    $display("%0t: result with nothing outstanding: %s",
                             $time, show_result(m_data));
                    mismatches++;
                end else begin
                    oldest_result = decoded_results.pop_front();
                    if (m_data !== oldest_result) begin
                        $display("%0t: result mismatch: expected %s, got %s", $time,
                                 show_result(oldest_result), show_result(m_data));
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        int unsigned pick;
        bit          lead_frame;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        for (int step = 0; step < StepCount; step++) begin
            // Reprogram timing only while the decoder is idle
            if (step != 0) begin
                wait_drained();
                load_timing(step_full[step], step_half[step], step_tol[step]);
            end
            sender_idle_pct   = step_tx_idle[step];
            receiver_idle_pct = step_rx_idle[step];
            phase_events      = 0;
            lead_frame        = 1'b1;
            if (step == 0) begin
                for (int i = 0; i < 25; i++) begin
                    queue_event(dir_ticks[i], dir_level[i]);
                end
            end
            // Mostly clean frames, some broken frames, some line noise
            while (phase_events < step_events[step]) begin
                pick = $urandom_range(99);
                if (pick < 88) begin
                    send_frame(lead_frame, pick >= 75);
                    lead_frame = 1'b0;
                end else begin
                    send_noise($urandom_range(6, 1));
                end
            end
        end
        wait_drained();
        if (mismatches == 0) begin
            $display("manchester_frame_decoder verification clean");
        end else begin
            $display("manchester_frame_decoder verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mfd_pkg.sv
rtl/core/mfd_front.sv
rtl/core/mfd_queue.sv
rtl/core/mfd_back.sv
rtl/core/manchester_frame_decoder.sv
tb/sv/manchester_frame_decoder_test.sv
